@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the interrupt flag controller.
// Used by modules that check their own logic; empty when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: property check failed");

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

@@ rtl/gifc_pkg.sv @@
// Shared types, codes and constants of the grouped interrupt flag controller.
// No dependencies; imported by gifc_core and the top level.
`timescale 1ns / 1ps

package gifc_pkg;

  localparam int NUM_GROUPS    = 4;
  localparam int MAX_GROUPS    = 8;
  localparam int FLAG_W        = 16;
  localparam int LINE_W        = 3;
  localparam int HOST_W        = 4;
  localparam int REQUEST_COUNT = 3;

  // Interrupt line driven by each group.
  localparam logic [1:0] GROUP_LINE [MAX_GROUPS] = '{
    2'd0, 2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2
  };

  typedef enum logic [2:0] {
    CMD_READ    = 3'd0,
    CMD_WRITE   = 3'd1,
    CMD_EXT_SET = 3'd2,
    CMD_RAISE   = 3'd3,
    CMD_TAKE    = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    SEL_FLAGS  = 3'd0,
    SEL_ENABLE = 3'd1,
    SEL_CLEAR  = 3'd2,
    SEL_SET    = 3'd3,
    SEL_TOHOST = 3'd4
  } sel_e;

  typedef struct packed {
    logic [2:0]        command;
    logic [2:0]        reg_select;
    logic [1:0]        group;
    logic [FLAG_W-1:0] data;
    logic [1:0]        request_index;
    logic              request_level;
  } item_t;

  typedef struct packed {
    logic [FLAG_W-1:0] read_data;
    logic [LINE_W-1:0] irq_lines;
    logic [HOST_W-1:0] host_events;
  } result_t;

endpackage

@@ rtl/grouped_interrupt_flag_controller.sv @@
// Top level of the grouped interrupt flag controller: stream ports,
// input register and result register. Depends on gifc_pkg and gifc_core.
`timescale 1ns / 1ps

// Usage
// - Slave stream carries one command word per handshake: bus read/write
//   of a group's flags, enables, clear, set or to-host register, an
//   external flag set, a request raise in group 0, or a host-event take.
// - Master stream returns exactly one result word per command word, in
//   order: read data (zero unless a read), the three interrupt lines as
//   they stand after the command, and the host events taken (zero unless
//   a take command).
// - An accepted word is held in the input register, passes once through
//   the update logic in gifc_core and is captured in the result register.
//   Throughput is one word per cycle while the receiver takes results; a
//   stalled receiver holds the flow, as described below.
// - Reset clears all flags, enables and host events and empties both
//   registers.
// - When the receiver stalls the result is held; the input register still
//   takes one more word, then tready drops until the result is taken.
module grouped_interrupt_flag_controller import gifc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] group, [17:2] data, [19:18] request_index, [20] request_level
  input  logic [23:0] s_axis_tdata,
  // [2:0] command, [5:3] reg_select
  input  logic [5:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] read_data, [18:16] irq_lines, [22:19] host_events
  output logic [23:0] m_axis_tdata
);

  item_t   in_q;
  logic    in_valid_q;
  result_t res_q;
  logic    res_valid_q;
  result_t core_res;
  logic    res_adv;
  logic    core_en;

  // Advance the result register when it is empty or being taken.
  assign res_adv       = !res_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || res_adv;
  assign core_en       = in_valid_q && res_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (res_adv) begin
        res_valid_q <= in_valid_q;
      end
    end
  end

  // Payload registers: the input loads on accept and the result loads when the core advances; both hold otherwise.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.command       <= s_axis_tuser[2:0];
      in_q.reg_select    <= s_axis_tuser[5:3];
      in_q.group         <= s_axis_tdata[1:0];
      in_q.data          <= s_axis_tdata[17:2];
      in_q.request_index <= s_axis_tdata[19:18];
      in_q.request_level <= s_axis_tdata[20];
    end
    if (core_en) begin
      res_q <= core_res;
    end
  end

  gifc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_en_i(core_en),
    .item_i   (in_q),
    .result_o (core_res)
  );

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = {1'b0, res_q.host_events, res_q.irq_lines, res_q.read_data};

endmodule

@@ rtl/gifc_core.sv @@
// Flag, enable and host-event state with the per-word update logic.
// Depends on gifc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gifc_core import gifc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    item_en_i,
  input  item_t   item_i,
  output result_t result_o
);

  logic [FLAG_W-1:0] flags_q  [NUM_GROUPS];
  logic [FLAG_W-1:0] flags_d  [NUM_GROUPS];
  logic [FLAG_W-1:0] enable_q [NUM_GROUPS];
  logic [FLAG_W-1:0] enable_d [NUM_GROUPS];
  logic [HOST_W-1:0] host_q;
  logic [HOST_W-1:0] host_d;
  logic [NUM_GROUPS-1:0] hit;
  logic [FLAG_W-1:0] rd_data;
  logic [HOST_W-1:0] ev_data;
  logic [LINE_W-1:0] lines;

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      hit[g]      = (int'(item_i.group) == g);
      flags_d[g]  = flags_q[g];
      enable_d[g] = enable_q[g];
    end
    host_d  = host_q;
    rd_data = '0;
    ev_data = '0;

    case (item_i.command)
      CMD_READ: begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
          if (hit[g] && item_i.reg_select == SEL_FLAGS) begin
            rd_data = rd_data | flags_q[g];
          end else if (hit[g] && item_i.reg_select == SEL_ENABLE) begin
            rd_data = rd_data | enable_q[g];
          end
        end
      end
      CMD_WRITE: begin
        if (item_i.reg_select == SEL_TOHOST) begin
          // Group field plays no part for the to-host register.
          host_d = host_q | item_i.data[HOST_W-1:0];
        end else begin
          for (int g = 0; g < NUM_GROUPS; g++) begin
            if (hit[g]) begin
              case (item_i.reg_select)
                SEL_ENABLE: enable_d[g] = item_i.data;
                SEL_CLEAR:  flags_d[g]  = flags_q[g] & ~item_i.data;
                SEL_SET:    flags_d[g]  = flags_q[g] | item_i.data;
                default:    ;
              endcase
            end
          end
        end
      end
      CMD_EXT_SET: begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
          if (hit[g]) begin
            flags_d[g] = flags_q[g] | item_i.data;
          end
        end
      end
      CMD_RAISE: begin
        if (item_i.request_level && (item_i.request_index < 2'(REQUEST_COUNT))) begin
          flags_d[0][{2'b00, item_i.request_index}] = 1'b1;
        end
      end
      CMD_TAKE: begin
        ev_data = host_q;
        host_d  = '0;
      end
      default: ;
    endcase

    // Line state after this word.
    lines = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if (|(flags_d[g] & enable_d[g])) begin
        lines[GROUP_LINE[g]] = 1'b1;
      end
    end
  end

  assign result_o.read_data   = rd_data;
  assign result_o.irq_lines   = lines;
  assign result_o.host_events = ev_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        flags_q[g]  <= '0;
        enable_q[g] <= '0;
      end
      host_q <= '0;
    end else if (item_en_i) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        flags_q[g]  <= flags_d[g];
        enable_q[g] <= enable_d[g];
      end
      host_q <= host_d;
    end
  end

  `ASSERT_PROP(a_take_clears_host, clk_i, rst_ni,
    (item_en_i && item_i.command == CMD_TAKE) |=> (host_q == '0))
  `ASSERT_NEVER(a_events_only_on_take, clk_i, rst_ni,
    (result_o.host_events != '0) && (item_i.command != CMD_TAKE))
  `ASSERT_NEVER(a_read_data_only_on_read, clk_i, rst_ni,
    (result_o.read_data != '0) && (item_i.command != CMD_READ))
  `ASSERT_PROP(a_idle_holds_host, clk_i, rst_ni,
    !item_en_i |=> $stable(host_q))

endmodule
